// ===== rtl/poly1305_mac_macros.svh =====
// Assertion macros for the Poly1305 authenticator.
// Included by the top level; needs clk and rst_n in the including scope.
`ifndef POLY1305_MAC_MACROS_SVH
`define POLY1305_MAC_MACROS_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante.
`define P1305_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("poly1305_mac: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define P1305_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("poly1305_mac: next-cycle check failed");

`else

`define P1305_ASSERT_IMP(label, ante, cons)
`define P1305_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/p1305_pkg.sv =====
// Shared types, constants and arithmetic helpers of the Poly1305 authenticator.
// Used by p1305_mul and poly1305_mac; depends on nothing.
package p1305_pkg;

    localparam int LIMB_W = 26;
    localparam int ACC_W  = 27;
    localparam int COEF_W = 29;
    localparam int SUM_W  = 60;
    localparam int LIMBS  = 5;

    localparam logic [LIMB_W-1:0] LIMB_MASK  = 26'h3ffffff;
    localparam logic [63:0]       CLAMP_LOW  = 64'h0FFFFFFC0FFFFFFF;
    localparam logic [63:0]       CLAMP_HIGH = 64'h0FFFFFFC0FFFFFFC;

    // Configuration register indexes
    localparam logic [1:0] CFG_KEY_R_LOW  = 2'd0;
    localparam logic [1:0] CFG_KEY_R_HIGH = 2'd1;
    localparam logic [1:0] CFG_KEY_S_LOW  = 2'd2;
    localparam logic [1:0] CFG_KEY_S_HIGH = 2'd3;

    typedef logic [LIMBS-1:0][ACC_W-1:0]  acc_t;
    typedef logic [LIMBS-1:0][LIMB_W-1:0] limbs_t;
    typedef logic [LIMBS-1:0][SUM_W-1:0]  sums_t;

    typedef struct packed {
        logic [63:0] data_low;
        logic [63:0] data_high;
        logic [4:0]  byte_count;
        logic        last_block;
        logic [63:0] expected_low;
        logic [63:0] expected_high;
    } p1305_req_t;

    typedef struct packed {
        logic [63:0] tag_low;
        logic [63:0] tag_high;
        logic        tag_match;
    } p1305_rsp_t;

    // Control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic       clear;
        logic       mac;
        logic       carry;
        logic [2:0] sel;
    } mul_ctrl_t;

    // Mask the valid bytes, set the pad bit and split into radix 2^26 limbs.
    function automatic limbs_t pad_block(input logic [63:0] lo, input logic [63:0] hi,
                                         input logic [4:0] cnt);
        logic [4:0]   n;
        logic [127:0] raw;
        logic [129:0] m;
        limbs_t       l;
        n   = (cnt > 5'd16) ? 5'd16 : cnt;
        raw = {hi, lo};
        m   = '0;
        for (int b = 0; b < 16; b++) begin
            if (5'(b) < n) begin
                m[8*b +: 8] = raw[8*b +: 8];
            end
        end
        for (int b = 0; b <= 16; b++) begin
            if (5'(b) == n) begin
                m[8*b] = 1'b1;
            end
        end
        l[0] = m[25:0];
        l[1] = m[51:26];
        l[2] = m[77:52];
        l[3] = m[103:78];
        l[4] = m[129:104];
        return l;
    endfunction

    // Clamp r and split into limbs.
    function automatic limbs_t clamp_r(input logic [63:0] rl, input logic [63:0] rh);
        logic [127:0] r;
        limbs_t       l;
        r    = {rh & CLAMP_HIGH, rl & CLAMP_LOW};
        l[0] = r[25:0];
        l[1] = r[51:26];
        l[2] = r[77:52];
        l[3] = r[103:78];
        l[4] = {2'b00, r[127:104]};
        return l;
    endfunction

    // Final carry pass over the accumulator limbs.
    function automatic acc_t final_carry(input acc_t h);
        logic [27:0] t0, t1, t2, t3, t4;
        acc_t        o;
        t1 = {1'b0, h[1]};
        t2 = {1'b0, h[2]} + 28'(t1[27:26]);
        t1 = {2'b00, t1[25:0]};
        t3 = {1'b0, h[3]} + 28'(t2[27:26]);
        t2 = {2'b00, t2[25:0]};
        t4 = {1'b0, h[4]} + 28'(t3[27:26]);
        t3 = {2'b00, t3[25:0]};
        t0 = {1'b0, h[0]} + 28'(t4[27:26]) * 28'd5;
        t4 = {2'b00, t4[25:0]};
        t1 = t1 + 28'(t0[27:26]);
        t0 = {2'b00, t0[25:0]};
        o[0] = t0[26:0];
        o[1] = t1[26:0];
        o[2] = t2[26:0];
        o[3] = t3[26:0];
        o[4] = t4[26:0];
        return o;
    endfunction

    // Subtract p when h is at least p, pack to 128 bits and add s.
    function automatic logic [127:0] final_tag(input acc_t h, input logic [127:0] s);
        logic [27:0] g0, g1, g2, g3, g4;
        logic        keep;
        acc_t        f;
        logic [63:0] lo, hi;
        g0   = {1'b0, h[0]} + 28'd5;
        g1   = {1'b0, h[1]} + 28'(g0[27:26]);
        g2   = {1'b0, h[2]} + 28'(g1[27:26]);
        g3   = {1'b0, h[3]} + 28'(g2[27:26]);
        g4   = {1'b0, h[4]} + 28'(g3[27:26]);
        keep = (g4 >= 28'(1 << 26));
        f[0] = keep ? {1'b0, g0[25:0]} : h[0];
        f[1] = keep ? {1'b0, g1[25:0]} : h[1];
        f[2] = keep ? {1'b0, g2[25:0]} : h[2];
        f[3] = keep ? {1'b0, g3[25:0]} : h[3];
        f[4] = keep ? {1'b0, g4[25:0]} : h[4];
        lo = 64'(f[0]) | (64'(f[1]) << 26) | (64'(f[2]) << 52);
        hi = (64'(f[2]) >> 12) | (64'(f[3]) << 14) | (64'(f[4][23:0]) << 40);
        return {hi, lo} + s;
    endfunction

endpackage

// ===== rtl/p1305_mul.sv =====
// Shared multiply-accumulate unit: one 27x29 product per cycle into five column sums,
// plus the carry step between columns. Depends on p1305_pkg.
module p1305_mul
    import p1305_pkg::*;
(
    input  logic              clk,
    input  mul_ctrl_t         ctrl,
    input  logic [ACC_W-1:0]  a,
    input  logic [COEF_W-1:0] b,
    output sums_t             d
);

    sums_t              d_reg;
    logic [SUM_W-1:0]   prod;
    logic [2:0]         sel_up;

    assign prod   = SUM_W'(a) * SUM_W'(b);
    assign sel_up = ctrl.sel + 3'd1;

    // Clear, accumulate one product, or move the carry up one column
    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            d_reg <= '0;
        end
        else if (ctrl.mac)
        begin
            d_reg[ctrl.sel] <= d_reg[ctrl.sel] + prod;
        end
        else if (ctrl.carry)
        begin
            d_reg[sel_up] <= d_reg[sel_up] + (d_reg[ctrl.sel] >> LIMB_W);
        end
    end

    assign d = d_reg;

endmodule

// ===== rtl/poly1305_mac.sv =====
// Poly1305 authenticator top level: key registers, sequencer, finish logic.
// Depends on p1305_pkg, p1305_mul and poly1305_mac_macros.svh.
//
// Usage:
//   Write the 32-byte key through cfg_we/cfg_index/cfg_data while idle
//   (index 0/1: r low/high before clamping, 2/3: s low/high).
//   Send each 16-byte message block as one request on req_valid/req_stall.
//   The block is busy (req_stall high) while it works on a request.
//   A block of 1..16 bytes is accepted, then runs 25 partial products through the
//   single shared 27x29 multiplier (one partial product per cycle), four
//   carry steps and one fold. A last request adds three finish steps
//   (carry pass, final reduce and s add, compare), then the tag is loaded
//   into the response register. A last request with zero bytes only runs the
//   finish. A non-last request with zero bytes is taken and dropped.
//   The response holds on rsp while rsp_stall is high; the block waits in its
//   final step until the response register is free.
//   Reset clears the key, the accumulator and the response valid.
`include "poly1305_mac_macros.svh"

module poly1305_mac
    import p1305_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        req_valid,
    output logic        req_stall,
    input  p1305_req_t  req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output p1305_rsp_t  rsp
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_CARRY = 3'd2;
    localparam logic [2:0] ST_FOLD  = 3'd3;
    localparam logic [2:0] ST_FIN1  = 3'd4;
    localparam logic [2:0] ST_FIN2  = 3'd5;
    localparam logic [2:0] ST_FIN3  = 3'd6;

    logic [2:0]   state_reg, state_next;
    logic [2:0]   i_reg, i_next;
    logic [2:0]   k_reg, k_next;
    logic         last_reg, last_next;
    logic         rsp_valid_reg, rsp_valid_next;
    acc_t         h_reg, h_next;
    logic [63:0]  key_r_low_reg, key_r_high_reg, key_s_low_reg, key_s_high_reg;
    limbs_t       r_reg;
    logic [127:0] exp_reg;
    logic [127:0] tag_reg;
    p1305_rsp_t   rsp_reg;

    logic         accept;
    logic         rsp_load;
    limbs_t       blk;
    mul_ctrl_t    ctrl;
    logic [2:0]   coef_idx;
    logic         coef_wrap;
    logic [LIMB_W-1:0] r_sel;
    logic [COEF_W-1:0] coef;
    sums_t        d;
    logic [33:0]  fold_c;
    logic [36:0]  fold_t0;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_load  = (state_reg == ST_FIN3) && !(rsp_valid_reg && rsp_stall);
    assign blk       = pad_block(req.data_low, req.data_high, req.byte_count);

    // Select r or 5r for the current column/row pair
    assign coef_wrap = (k_reg < i_reg);
    assign coef_idx  = coef_wrap ? (k_reg + 3'd5 - i_reg) : (k_reg - i_reg);
    assign r_sel     = r_reg[coef_idx];
    assign coef      = coef_wrap ? (COEF_W'(r_sel) + (COEF_W'(r_sel) << 2)) : COEF_W'(r_sel);

    // Fold the top carry back into the low limb
    assign fold_c  = 34'(d[4] >> LIMB_W);
    assign fold_t0 = 37'(d[0][LIMB_W-1:0]) + 37'(fold_c) * 37'd5;

    p1305_mul u_mul (
        .clk  (clk),
        .ctrl (ctrl),
        .a    (h_reg[i_reg]),
        .b    (coef),
        .d    (d)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        last_next      = last_reg;
        h_next         = h_reg;
        rsp_valid_next = rsp_valid_reg;
        ctrl           = '0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    last_next = req.last_block;
                    if (req.byte_count != 5'd0)
                    begin
                        for (int l = 0; l < LIMBS; l++)
                        begin
                            h_next[l] = h_reg[l] + ACC_W'(blk[l]);
                        end
                        ctrl.clear = 1'b1;
                        i_next     = 3'd0;
                        k_next     = 3'd0;
                        state_next = ST_MUL;
                    end
                    else if (req.last_block)
                    begin
                        state_next = ST_FIN1;
                    end
                end
            end
            ST_MUL:
            begin
                ctrl.mac = 1'b1;
                ctrl.sel = k_reg;
                if (k_reg == 3'd4)
                begin
                    k_next = 3'd0;
                    if (i_reg == 3'd4)
                    begin
                        state_next = ST_CARRY;
                    end
                    else
                    begin
                        i_next = i_reg + 3'd1;
                    end
                end
                else
                begin
                    k_next = k_reg + 3'd1;
                end
            end
            ST_CARRY:
            begin
                ctrl.carry = 1'b1;
                ctrl.sel   = k_reg;
                if (k_reg == 3'd3)
                begin
                    state_next = ST_FOLD;
                end
                else
                begin
                    k_next = k_reg + 3'd1;
                end
            end
            ST_FOLD:
            begin
                h_next[0]  = ACC_W'(fold_t0[LIMB_W-1:0]);
                h_next[1]  = ACC_W'(37'(d[1][LIMB_W-1:0]) + (fold_t0 >> LIMB_W));
                h_next[2]  = ACC_W'(d[2][LIMB_W-1:0]);
                h_next[3]  = ACC_W'(d[3][LIMB_W-1:0]);
                h_next[4]  = ACC_W'(d[4][LIMB_W-1:0]);
                state_next = last_reg ? ST_FIN1 : ST_IDLE;
            end
            ST_FIN1:
            begin
                h_next     = final_carry(h_reg);
                state_next = ST_FIN2;
            end
            ST_FIN2:
            begin
                state_next = ST_FIN3;
            end
            ST_FIN3:
            begin
                if (rsp_load)
                begin
                    rsp_valid_next = 1'b1;
                    h_next         = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state, key and accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            i_reg          <= 3'd0;
            k_reg          <= 3'd0;
            last_reg       <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            h_reg          <= '0;
            key_r_low_reg  <= '0;
            key_r_high_reg <= '0;
            key_s_low_reg  <= '0;
            key_s_high_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            k_reg         <= k_next;
            last_reg      <= last_next;
            rsp_valid_reg <= rsp_valid_next;
            h_reg         <= h_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_KEY_R_LOW:  key_r_low_reg  <= cfg_data;
                    CFG_KEY_R_HIGH: key_r_high_reg <= cfg_data;
                    CFG_KEY_S_LOW:  key_s_low_reg  <= cfg_data;
                    CFG_KEY_S_HIGH: key_s_high_reg <= cfg_data;
                    default:        key_r_low_reg  <= key_r_low_reg;
                endcase
            end
        end
    end

    // Payload: clamped r, expected tag, computed tag, response
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            r_reg   <= clamp_r(key_r_low_reg, key_r_high_reg);
            exp_reg <= {req.expected_high, req.expected_low};
        end
        if (state_reg == ST_FIN2)
        begin
            tag_reg <= final_tag(h_reg, {key_s_high_reg, key_s_low_reg});
        end
        if (rsp_load)
        begin
            rsp_reg.tag_low   <= tag_reg[63:0];
            rsp_reg.tag_high  <= tag_reg[127:64];
            rsp_reg.tag_match <= (tag_reg == exp_reg);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks
    `P1305_ASSERT_IMP(a_mul_index_range, state_reg == ST_MUL, (i_reg < 3'd5) && (k_reg < 3'd5))
    `P1305_ASSERT_NEXT(a_mul_sweep_end, (state_reg == ST_MUL) && (i_reg == 3'd4) && (k_reg == 3'd4), state_reg == ST_CARRY)
    `P1305_ASSERT_NEXT(a_tag_clears_acc, rsp_load, (state_reg == ST_IDLE) && rsp_valid_reg && (h_reg == '0))

endmodule

// ===== tb/tb_poly1305_mac.sv =====
// Self-checking testbench for poly1305_mac: directed and random message blocks
// are checked against a limb-level Poly1305 predictor held in this file.
// Depends on p1305_pkg and the poly1305_mac RTL.
module tb_poly1305_mac
    import p1305_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         DRAIN_CYCLES = 64;
    localparam int         LONG_HOLD    = 2000;
    localparam bit [63:0]  LIMB_ONES    = 64'h3ff_ffff;
    localparam bit [63:0]  ALL_ONES     = 64'hffff_ffff_ffff_ffff;

    typedef bit [4:0][31:0] acc_limbs_t;
    typedef enum bit [1:0] {TAG_AS_IS, TAG_EXACT, TAG_ONE_OFF} tag_sel_e;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = CFG_KEY_R_LOW;
    logic [63:0] cfg_data  = '0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    p1305_req_t  req       = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    p1305_rsp_t  rsp;

    // Key registers as the block should hold them
    bit [63:0]   key_word [4];
    acc_limbs_t  gen_acc = '0;
    acc_limbs_t  mac_acc = '0;
    p1305_req_t  pending_blocks [$];
    p1305_rsp_t  expected_tags [$];
    int          blocks_queued = 0;
    int          err_count = 0;
    logic [4:0]  send_gap = '0;
    int          hold_left = 0;
    bit          quiet = 1'b0;
    bit          long_hold_req = 1'b0;
    bit          long_hold_done = 1'b0;

    poly1305_mac u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Absorb one block into the accumulator; on a last block also form the tag
    // and clear the accumulator. Returns 1 when a tag comes out.
    function automatic bit mac_step(input acc_limbs_t h_in, input p1305_req_t q,
                                    output acc_limbs_t h_out, output p1305_rsp_t tag);
        int unsigned n;
        bit [127:0]  raw;
        bit [129:0]  blk;
        bit [129:0]  rc;
        bit [31:0]   h [5];
        bit [31:0]   g [5];
        bit [31:0]   rl [5];
        bit [63:0]   d [5];
        bit [63:0]   c;
        bit [63:0]   t0;
        bit [63:0]   lo;
        bit [63:0]   hi;
        bit [127:0]  sum;
        for (int i = 0; i < 5; i++) h[i] = h_in[i];
        n = (q.byte_count > 5'd16) ? 16 : q.byte_count;
        // keep the valid bytes, place the pad bit, then multiply by clamped r
        if (n != 0)
        begin
            raw = {q.data_high, q.data_low};
            blk = '0;
            for (int b = 0; b < 16; b++)
                if (b < n) blk[8*b +: 8] = raw[8*b +: 8];
            blk[8*n] = 1'b1;
            rc = {2'b00, key_word[CFG_KEY_R_HIGH] & CLAMP_HIGH,
                  key_word[CFG_KEY_R_LOW] & CLAMP_LOW};
            for (int i = 0; i < 5; i++)
            begin
                h[i] += 32'(blk[26*i +: 26]);
                rl[i] = 32'(rc[26*i +: 26]);
            end
            for (int i = 0; i < 5; i++)
            begin
                d[i] = '0;
                for (int j = 0; j < 5; j++)
                    d[i] += 64'(h[j]) * ((j <= i) ? 64'(rl[i-j]) : 64'(rl[i-j+5]) * 5);
            end
            for (int i = 0; i < 4; i++) d[i+1] += d[i] >> 26;
            c    = d[4] >> 26;
            t0   = (d[0] & LIMB_ONES) + c * 5;
            h[0] = 32'(t0 & LIMB_ONES);
            h[1] = 32'((d[1] & LIMB_ONES) + (t0 >> 26));
            for (int i = 2; i < 5; i++) h[i] = 32'(d[i] & LIMB_ONES);
        end
        tag = '0;
        for (int i = 0; i < 5; i++) h_out[i] = h[i];
        if (!q.last_block) return 1'b0;

        // carry pass, wrapping the top carry back times five
        for (int i = 1; i < 5; i++)
        begin
            c = 64'(h[i] >> 26);
            h[i] &= 32'(LIMB_ONES);
            if (i < 4) h[i+1] += 32'(c);
            else h[0] += 32'(c * 5);
        end
        c = 64'(h[0] >> 26);
        h[0] &= 32'(LIMB_ONES);
        h[1] += 32'(c);
        // take h + 5 - 2^130 when it does not go negative
        c = 64'd5;
        for (int i = 0; i < 4; i++)
        begin
            g[i] = h[i] + 32'(c);
            c    = 64'(g[i] >> 26);
            g[i] &= 32'(LIMB_ONES);
        end
        g[4] = h[4] + 32'(c) - 32'h0400_0000;
        if (!g[4][31]) h = g;
        lo  = 64'(h[0]) | (64'(h[1]) << 26) | (64'(h[2]) << 52);
        hi  = (64'(h[2]) >> 12) | (64'(h[3]) << 14) | (64'(h[4] & 32'hff_ffff) << 40);
        sum = {hi, lo} + {key_word[CFG_KEY_S_HIGH], key_word[CFG_KEY_S_LOW]};
        tag.tag_low   = sum[63:0];
        tag.tag_high  = sum[127:64];
        tag.tag_match = (sum == {q.expected_high, q.expected_low});
        h_out = '0;
        return 1'b1;
    endfunction

    function automatic p1305_req_t fixed_block(input bit [63:0] lo, input bit [63:0] hi,
                                               input bit [4:0] cnt, input bit last,
                                               input bit [63:0] exp_lo,
                                               input bit [63:0] exp_hi);
        p1305_req_t q;
        q.data_low      = lo;
        q.data_high     = hi;
        q.byte_count    = cnt;
        q.last_block    = last;
        q.expected_low  = exp_lo;
        q.expected_high = exp_hi;
        return q;
    endfunction

    // Random content; a tidy block has its unused bytes zeroed
    function automatic p1305_req_t random_block(input bit tidy, input bit [4:0] cnt);
        bit [127:0] d;
        d = {$urandom, $urandom, $urandom, $urandom};
        if (tidy)
            for (int b = 0; b < 16; b++)
                if (b >= cnt) d[8*b +: 8] = 8'h00;
        return fixed_block(d[63:0], d[127:64], cnt, 1'b0,
                           {$urandom, $urandom}, {$urandom, $urandom});
    endfunction

    // Advance the stimulus-side accumulator, fill in the expected tag, queue it
    task automatic queue_block(input p1305_req_t q, input tag_sel_e sel);
        acc_limbs_t nxt;
        p1305_rsp_t t;
        bit [127:0] want;
        if (mac_step(gen_acc, q, nxt, t) && sel != TAG_AS_IS)
        begin
            want = {t.tag_high, t.tag_low};
            if (sel == TAG_ONE_OFF) want[$urandom_range(0, 127)] ^= 1'b1;
            {q.expected_high, q.expected_low} = want;
        end
        gen_acc = nxt;
        pending_blocks.push_back(q);
        blocks_queued++;
    endtask

    // Mostly well-formed messages; some carry short counts, oversize counts
    // and junk beyond the valid bytes
    task automatic queue_message(input bit close);
        bit         noisy;
        int         blocks;
        bit [4:0]   cnt;
        p1305_req_t q;
        noisy  = ($urandom_range(0, 4) == 0);
        blocks = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 3);
        for (int b = 0; b < blocks; b++)
        begin
            cnt = (noisy && $urandom_range(0, 2) == 0) ? 5'($urandom_range(0, 31)) : 5'd16;
            queue_block(random_block(!noisy, cnt), TAG_AS_IS);
        end
        if (close)
        begin
            cnt = (noisy && $urandom_range(0, 1) == 0) ? 5'($urandom_range(17, 31))
                                                       : 5'($urandom_range(0, 16));
            q = random_block(!noisy, cnt);
            q.last_block = 1'b1;
            queue_block(q, tag_sel_e'($urandom_range(0, 2)));
        end
    endtask

    // Queue about count blocks; optionally leave the last message open
    task automatic queue_random(input int count, input bit close);
        int start;
        start = blocks_queued;
        while (blocks_queued - start < count) queue_message(1'b1);
        if (!close) queue_message(1'b0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input bit [63:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        key_word[idx] = val;
    endtask

    task automatic load_key(input bit [3:0] which, input bit [63:0] r_lo, input bit [63:0] r_hi,
                            input bit [63:0] s_lo, input bit [63:0] s_hi);
        if (which[CFG_KEY_R_LOW])  write_reg(CFG_KEY_R_LOW, r_lo);
        if (which[CFG_KEY_R_HIGH]) write_reg(CFG_KEY_R_HIGH, r_hi);
        if (which[CFG_KEY_S_LOW])  write_reg(CFG_KEY_S_LOW, s_lo);
        if (which[CFG_KEY_S_HIGH]) write_reg(CFG_KEY_S_HIGH, s_hi);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Hold until every request is taken and every tag is back, then let
    // any open non-last block finish
    task automatic wait_idle();
        do @(negedge clk);
        while (pending_blocks.size() != 0 || req_valid || expected_tags.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Driver: offer queued requests, hold while stalled, idle in bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            send_gap  <= '0;
        end
        else if (!req_valid || !req_stall)
        begin
            if (send_gap != 0)
            begin
                req_valid <= 1'b0;
                send_gap  <= send_gap - 5'd1;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                req_valid <= 1'b0;
                send_gap  <= 5'($urandom_range(0, 17));
            end
            else if (pending_blocks.size() != 0)
            begin
                req       <= pending_blocks.pop_front();
                req_valid <= 1'b1;
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall in random bursts, plus one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            hold_left <= 0;
        end
        else if (long_hold_req && !long_hold_done)
        begin
            long_hold_done <= 1'b1;
            rsp_stall      <= 1'b1;
            hold_left      <= LONG_HOLD;
        end
        else if (hold_left != 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= $urandom_range(0, 17);
        end
        else
        begin
            rsp_stall <= 1'b0;
        end
    end

    // Monitor: check each tag against the oldest expectation, predict on accept
    always @(posedge clk)
    begin
        acc_limbs_t nxt;
        p1305_rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_tags.size() == 0)
                begin
                    $error("unexpected tag %h_%h", rsp.tag_high, rsp.tag_low);
                    err_count++;
                end
                else
                begin
                    want = expected_tags.pop_front();
                    if (rsp.tag_low !== want.tag_low)
                    begin
                        $error("tag_low: expected %h, got %h", want.tag_low, rsp.tag_low);
                        err_count++;
                    end
                    if (rsp.tag_high !== want.tag_high)
                    begin
                        $error("tag_high: expected %h, got %h", want.tag_high, rsp.tag_high);
                        err_count++;
                    end
                    if (rsp.tag_match !== want.tag_match)
                    begin
                        $error("tag_match: expected %b, got %b", want.tag_match, rsp.tag_match);
                        err_count++;
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                if (mac_step(mac_acc, req, nxt, want)) expected_tags.push_back(want);
                mac_acc = nxt;
            end
        end
    end

    // Stimulus sequence
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset key: empty message and one full block
        queue_block(fixed_block('0, '0, 5'd0, 1'b1, '0, '0), TAG_AS_IS);
        queue_block(fixed_block(ALL_ONES, ALL_ONES, 5'd16, 1'b1, '0, '0), TAG_EXACT);
        wait_idle();

        // published test key and message
        load_key(4'hf, 64'h336d555778bed685, 64'ha806d542fe52447f,
                 64'hfdb20dfb8a800301, 64'h1bf54941aff6bf4a);
        queue_block(fixed_block(64'h72676f7470797243, 64'h6f46206369687061, 5'd16, 1'b0,
                                '0, '0), TAG_AS_IS);
        queue_block(fixed_block(64'h65736552206d7572, 64'h6f72472068637261, 5'd16, 1'b0,
                                '0, '0), TAG_AS_IS);
        queue_block(fixed_block(64'h7075, '0, 5'd2, 1'b1,
                                64'hc6365130c11d06a8, 64'ha927010caf8b2bc2), TAG_AS_IS);
        // empty message gives s alone
        queue_block(fixed_block('0, '0, 5'd0, 1'b1, '0, '0), TAG_EXACT);
        // zero-byte non-last is dropped; junk past the count is masked
        queue_block(fixed_block(ALL_ONES, ALL_ONES, 5'd0, 1'b0, '0, '0), TAG_AS_IS);
        queue_block(fixed_block(ALL_ONES, ALL_ONES, 5'd1, 1'b0, '0, '0), TAG_AS_IS);
        queue_block(fixed_block(ALL_ONES, ALL_ONES, 5'd7, 1'b0, '0, '0), TAG_AS_IS);
        queue_block(fixed_block(ALL_ONES, ALL_ONES, 5'd8, 1'b0, '0, '0), TAG_AS_IS);
        queue_block(fixed_block(ALL_ONES, ALL_ONES, 5'd9, 1'b0, '0, '0), TAG_AS_IS);
        queue_block(fixed_block(ALL_ONES, ALL_ONES, 5'd15, 1'b0, '0, '0), TAG_AS_IS);
        queue_block(fixed_block(ALL_ONES, ALL_ONES, 5'd16, 1'b1, ALL_ONES, ALL_ONES),
                    TAG_AS_IS);
        // oversize counts saturate; zero-byte last closes what was absorbed
        queue_block(fixed_block(ALL_ONES, ALL_ONES, 5'd31, 1'b0, '0, '0), TAG_AS_IS);
        queue_block(fixed_block(ALL_ONES, ALL_ONES, 5'd17, 1'b0, '0, '0), TAG_AS_IS);
        queue_block(fixed_block(ALL_ONES, ALL_ONES, 5'd0, 1'b1, '0, '0), TAG_EXACT);
        queue_block(fixed_block('0, '0, 5'd16, 1'b1, '0, '0), TAG_AS_IS);
        queue_block(fixed_block(ALL_ONES, ALL_ONES, 5'd16, 1'b1, '0, '0), TAG_ONE_OFF);
        wait_idle();

        // all-ones key, long receiver hold-off; leave a message open
        load_key(4'hf, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        long_hold_req <= 1'b1;
        for (int b = 0; b < 8; b++)
            queue_block(fixed_block(ALL_ONES, ALL_ONES, 5'd16, 1'b0, '0, '0), TAG_AS_IS);
        queue_block(fixed_block(ALL_ONES, ALL_ONES, 5'd16, 1'b1, '0, '0), TAG_EXACT);
        queue_random(400, 1'b0);
        wait_idle();

        // random r with zero s, continuing the open message
        load_key(4'hf, {$urandom, $urandom}, {$urandom, $urandom}, '0, '0);
        queue_random(400, 1'b0);
        wait_idle();

        // change two registers only
        load_key((4'b1 << CFG_KEY_R_LOW) | (4'b1 << CFG_KEY_S_HIGH), {$urandom, $urandom}, '0,
                 '0, {$urandom, $urandom});
        queue_random(400, 1'b1);
        wait_idle();

        load_key(4'hf, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom});
        queue_random(400, 1'b1);
        wait_idle();

        // closing stretch with no idling on either side
        load_key(4'hf, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom});
        quiet <= 1'b1;
        queue_random(400, 1'b1);
        wait_idle();

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Run limit
    initial
    begin
        #(10_000_000);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
